FILE: hw/rtl/nssd_pkg.sv
package nssd_pkg;

  // Length table geometry and index width are fixed by the field widths.
  localparam int unsigned TableDepth   = 1024;
  localparam int unsigned TableAddrW   = $clog2(TableDepth);
  localparam int unsigned LengthW      = 16;
  localparam int unsigned IndexW       = 16;
  localparam int unsigned MaxPipeDepth = 15;
  localparam int unsigned MinPipeDepth = 3;
  localparam int unsigned BusyW        = MaxPipeDepth;
  localparam int unsigned AddrW        = 36;
  localparam int unsigned StrideW      = 16;
  localparam int unsigned ProductW     = StrideW + IndexW;
  localparam int unsigned DelayW       = 10;
  localparam int unsigned PropW        = 8;
  localparam int unsigned WaitW        = 8;
  localparam int unsigned DepthW       = 4;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 36;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNeuronCount   = 3'd0,
    CfgWaitCycles    = 3'd1,
    CfgFixedDelay    = 3'd2,
    CfgSynapseStride = 3'd3,
    CfgBaseAddress   = 3'd4,
    CfgPropagatorId  = 3'd5,
    CfgPipeDepth     = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    ReqTick       = 1'b0,
    ReqTableWrite = 1'b1
  } req_type_e;

  // Result of the state update, carried one stage before the output register.
  typedef struct packed {
    logic                axon_valid;
    logic [ProductW-1:0] product;
    logic [DelayW-1:0]   delay;
    logic [PropW-1:0]    propagator;
    logic                inhibitory;
    logic                spike_pop;
    logic                fin_valid;
    logic                fin_value;
    logic                went_idle;
  } mid_t;

endpackage

FILE: hw/rtl/nssd_ram.sv
module nssd_ram
  #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/neuron_scan_spike_dispatcher.sv
// Neuron scan spike dispatcher. Each accepted input item is one tick of the core (or a
// length table write) and yields exactly one result item. The block takes one item per
// cycle unless a stall from the output side holds it; an item passes an input register, a
// state-update stage that also issues the length table read and the stride multiply,
// and an output register, and its result transfers when the output side is not stalled.
// The scan state, the occupancy shift registers and the idle/finish flags change in the
// middle stage, one item per cycle when it advances. The 1024-entry length table is a
// single RAM with a registered read; entries that were never written read back
// undefined values.
module neuron_scan_spike_dispatcher
  import nssd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic                ts_valid_i,
  input  logic                ts_value_i,
  input  logic                spike_present_i,
  input  logic [IndexW-1:0]   spike_head_i,
  input  logic [TableAddrW-1:0] table_slot_i,
  input  logic [LengthW-1:0]  table_word_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                axon_valid_o,
  output logic [AddrW-1:0]    axon_address_o,
  output logic [LengthW-1:0]  axon_length_o,
  output logic [DelayW-1:0]   axon_delay_o,
  output logic [PropW-1:0]    axon_propagator_o,
  output logic                axon_inhibitory_o,
  output logic                spike_pop_o,
  output logic                fin_valid_o,
  output logic                fin_value_o,
  output logic                went_idle_o
);

  // Configuration registers.
  logic [IndexW-1:0]  neuron_count_q;
  logic [WaitW-1:0]   wait_cycles_q;
  logic [DelayW-1:0]  fixed_delay_q;
  logic [StrideW-1:0] synapse_stride_q;
  logic [AddrW-1:0]   base_address_q;
  logic [PropW-1:0]   propagator_id_q;
  logic [DepthW-1:0]  pipe_depth_q;

  // Scan state.
  logic [IndexW-1:0] scan_index_q, scan_index_d;
  logic [WaitW-1:0]  wait_count_q, wait_count_d;
  logic              last_parity_q, last_parity_d;
  logic [BusyW-1:0]  pipe_busy_q, pipe_busy_d;
  logic [BusyW-1:0]  spike_busy_q, spike_busy_d;
  logic              idle_flag_q, idle_flag_d;
  logic              finish_flag_q, finish_flag_d;

  // Input register.
  logic                  a_valid_q;
  logic                  a_req_type_q;
  logic                  a_ts_valid_q;
  logic                  a_ts_value_q;
  logic                  a_spike_present_q;
  logic [IndexW-1:0]     a_spike_head_q;
  logic [TableAddrW-1:0] a_table_slot_q;
  logic [LengthW-1:0]    a_table_word_q;

  // Middle stage and output register.
  logic                  b_valid_q;
  mid_t                  b_q, b_d;
  logic                  c_valid_q;
  logic                  c_axon_valid_q;
  logic [AddrW-1:0]      c_address_q;
  logic [LengthW-1:0]    c_length_q;
  logic [DelayW-1:0]     c_delay_q;
  logic [PropW-1:0]      c_propagator_q;
  logic                  c_inhibitory_q;
  logic                  c_spike_pop_q;
  logic                  c_fin_valid_q;
  logic                  c_fin_value_q;
  logic                  c_went_idle_q;

  logic c_ready, b_ready, a_ready;
  logic in_xfer, a_adv, b_adv;
  logic is_write;

  logic [LengthW-1:0]    ram_rdata;
  logic                  ram_re;
  logic [TableAddrW-1:0] ram_raddr;

  // Combinational scan step signals.
  logic [DepthW-1:0]   depth_eff;
  logic [BusyW-1:0]    pmask, smask;
  logic [IndexW-1:0]   idx0, idx1;
  logic                hit;
  logic                busy;
  logic [IndexW+2:0]   idx_times5;
  logic [IndexW+2:0]   count_times4;

  assign c_ready    = !c_valid_q || !out_stall_i;
  assign b_ready    = !b_valid_q || c_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_stall_o = !a_ready;
  assign in_xfer    = in_valid_i && a_ready;
  assign a_adv      = a_valid_q && b_ready;
  assign b_adv      = b_valid_q && c_ready;
  assign is_write   = (req_type_e'(a_req_type_q) == ReqTableWrite);

  always_comb begin
    // The 4-bit depth register cannot exceed the largest supported depth.
    if (pipe_depth_q < DepthW'(MinPipeDepth)) begin
      depth_eff = DepthW'(MinPipeDepth);
    end else begin
      depth_eff = pipe_depth_q;
    end
    // Pipe mask covers bits 1 to depth-3, spike mask bits 1 to depth-1.
    for (int k = 0; k < BusyW; k++) begin
      pmask[k] = (k >= 1) && (k + 3 <= int'(depth_eff));
      smask[k] = (k >= 1) && (k + 1 <= int'(depth_eff));
    end
  end

  always_comb begin
    last_parity_d = last_parity_q;
    scan_index_d  = scan_index_q;
    wait_count_d  = wait_count_q;
    pipe_busy_d   = pipe_busy_q;
    spike_busy_d  = spike_busy_q;
    idle_flag_d   = idle_flag_q;
    finish_flag_d = finish_flag_q;
    b_d           = '0;
    hit           = 1'b0;
    idx0          = scan_index_q;
    idx1          = scan_index_q;
    busy          = 1'b0;

    if (a_ts_valid_q && (last_parity_q != a_ts_value_q)) begin
      last_parity_d = a_ts_value_q;
      idx0          = '0;
    end
    scan_index_d = idx0;
    pipe_busy_d  = (pipe_busy_q << 1) & pmask;
    spike_busy_d = (spike_busy_q << 1) & smask;
    idx_times5   = (IndexW+3)'(idx0) * (IndexW+3)'(5);
    count_times4 = {1'b0, neuron_count_q, 2'b00};

    if (idx0 != neuron_count_q) begin
      if (wait_count_q != '0) begin
        wait_count_d = wait_count_q - WaitW'(1);
      end else begin
        hit = a_spike_present_q && (a_spike_head_q == idx0);
        if (hit) begin
          spike_busy_d[0] = 1'b1;
          b_d.axon_valid  = 1'b1;
          b_d.product     = ProductW'(synapse_stride_q) * ProductW'(idx0);
          b_d.delay       = fixed_delay_q;
          b_d.propagator  = propagator_id_q;
          b_d.inhibitory  = idx_times5 > count_times4;
          b_d.spike_pop   = 1'b1;
        end else begin
          pipe_busy_d[0] = 1'b1;
        end
        idx1         = idx0 + IndexW'(1);
        scan_index_d = idx1;
        wait_count_d = wait_cycles_q;
        if (idx1 == neuron_count_q) begin
          finish_flag_d = 1'b1;
          b_d.fin_valid = 1'b1;
          b_d.fin_value = 1'b1;
        end
      end
    end

    busy = |(pipe_busy_d | spike_busy_d);
    // A start pulse replaces a finish pulse on the same tick.
    if (idle_flag_q && busy && finish_flag_d) begin
      idle_flag_d   = 1'b0;
      finish_flag_d = 1'b0;
      b_d.fin_valid = 1'b1;
      b_d.fin_value = 1'b0;
    end else if (!idle_flag_q && !busy && finish_flag_d) begin
      idle_flag_d   = 1'b1;
      b_d.went_idle = 1'b1;
    end
  end

  assign ram_re    = a_adv && !is_write && hit;
  assign ram_raddr = idx0[TableAddrW-1:0];

  nssd_ram #(
    .Width (LengthW),
    .Depth (TableDepth)
  ) u_length_table (
    .clk_i   (clk_i),
    .we_i    (a_adv && is_write),
    .waddr_i (a_table_slot_q),
    .wdata_i (a_table_word_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Configuration and scan state. Write only while idle; not enforced by the block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neuron_count_q   <= IndexW'(1024);
      wait_cycles_q    <= '0;
      fixed_delay_q    <= DelayW'(1);
      synapse_stride_q <= StrideW'(100);
      base_address_q   <= '0;
      propagator_id_q  <= '0;
      pipe_depth_q     <= DepthW'(8);
      scan_index_q     <= IndexW'(1024);
      wait_count_q     <= '0;
      last_parity_q    <= 1'b0;
      pipe_busy_q      <= '0;
      spike_busy_q     <= '0;
      idle_flag_q      <= 1'b1;
      finish_flag_q    <= 1'b1;
    end else begin
      if (a_adv && !is_write) begin
        scan_index_q  <= scan_index_d;
        wait_count_q  <= wait_count_d;
        last_parity_q <= last_parity_d;
        pipe_busy_q   <= pipe_busy_d;
        spike_busy_q  <= spike_busy_d;
        idle_flag_q   <= idle_flag_d;
        finish_flag_q <= finish_flag_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgNeuronCount: begin
            neuron_count_q <= cfg_data_i[IndexW-1:0];
            scan_index_q   <= cfg_data_i[IndexW-1:0];
          end
          CfgWaitCycles: begin
            wait_cycles_q <= cfg_data_i[WaitW-1:0];
            wait_count_q  <= cfg_data_i[WaitW-1:0];
          end
          CfgFixedDelay:    fixed_delay_q    <= cfg_data_i[DelayW-1:0];
          CfgSynapseStride: synapse_stride_q <= cfg_data_i[StrideW-1:0];
          CfgBaseAddress:   base_address_q   <= cfg_data_i[AddrW-1:0];
          CfgPropagatorId:  propagator_id_q  <= cfg_data_i[PropW-1:0];
          CfgPipeDepth:     pipe_depth_q     <= cfg_data_i[DepthW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (c_ready) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_req_type_q      <= req_type_i;
      a_ts_valid_q      <= ts_valid_i;
      a_ts_value_q      <= ts_value_i;
      a_spike_present_q <= spike_present_i;
      a_spike_head_q    <= spike_head_i;
      a_table_slot_q    <= table_slot_i;
      a_table_word_q    <= table_word_i;
    end
    if (a_adv) begin
      b_q <= is_write ? '0 : b_d;
    end
    if (b_adv) begin
      c_axon_valid_q <= b_q.axon_valid;
      c_address_q    <= b_q.axon_valid ?
                        (base_address_q + AddrW'(b_q.product)) : '0;
      c_length_q     <= b_q.axon_valid ? ram_rdata : '0;
      c_delay_q      <= b_q.delay;
      c_propagator_q <= b_q.propagator;
      c_inhibitory_q <= b_q.inhibitory;
      c_spike_pop_q  <= b_q.spike_pop;
      c_fin_valid_q  <= b_q.fin_valid;
      c_fin_value_q  <= b_q.fin_value;
      c_went_idle_q  <= b_q.went_idle;
    end
  end

  assign out_valid_o       = c_valid_q;
  assign axon_valid_o      = c_axon_valid_q;
  assign axon_address_o    = c_address_q;
  assign axon_length_o     = c_length_q;
  assign axon_delay_o      = c_delay_q;
  assign axon_propagator_o = c_propagator_q;
  assign axon_inhibitory_o = c_inhibitory_q;
  assign spike_pop_o       = c_spike_pop_q;
  assign fin_valid_o       = c_fin_valid_q;
  assign fin_value_o       = c_fin_value_q;
  assign went_idle_o       = c_went_idle_q;

endmodule
